### rtl/core/salsa_pkg.sv
// Salsa20 package: shared types, register indexes, constants and round functions.
// No dependencies; imported by the controller, datapath and top level.
package salsa_pkg;

    typedef logic [31:0]        word_t;
    typedef logic [15:0][31:0]  matrix_t;
    typedef logic [3:0][31:0]   quad_t;

    localparam int DATA_W   = 64;
    localparam int COUNT_W  = 4;
    localparam int TDATA_W  = 72;
    localparam int CFG_IDX_W = 3;
    localparam int ROUNDS_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDS   = 3'd6;

    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 5'd20;

    // "expand 32-byte k"
    localparam word_t SIGMA0 = 32'h6170_7865;
    localparam word_t SIGMA1 = 32'h3320_646e;
    localparam word_t SIGMA2 = 32'h7962_2d32;
    localparam word_t SIGMA3 = 32'h6b20_6574;

    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic load;     // load input matrix into working state
        logic round;    // run one half round
        logic row;      // 0: column round, 1: row round
        logic finish;   // feed-forward add and counter increment
        logic emit;     // move result into output register
    } dp_cmd_t;

    typedef struct packed {
        logic                block_needed;
        logic [ROUNDS_W-1:0] half_rounds;
        logic                out_free;
    } dp_status_t;

    function automatic word_t rotl(word_t v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic quad_t quarter_round(word_t a, word_t b, word_t c, word_t d);
        word_t s;
        word_t a1, b1, c1, d1;
        quad_t q;
        s  = a + d;
        b1 = b ^ rotl(s, 7);
        s  = b1 + a;
        c1 = c ^ rotl(s, 9);
        s  = c1 + b1;
        d1 = d ^ rotl(s, 13);
        s  = d1 + c1;
        a1 = a ^ rotl(s, 18);
        q  = {d1, c1, b1, a1};
        return q;
    endfunction

    function automatic matrix_t column_round(matrix_t x);
        matrix_t y;
        quad_t q;
        y = x;
        q = quarter_round(x[0], x[4], x[8], x[12]);
        y[0] = q[0];  y[4] = q[1];  y[8] = q[2];  y[12] = q[3];
        q = quarter_round(x[5], x[9], x[13], x[1]);
        y[5] = q[0];  y[9] = q[1];  y[13] = q[2]; y[1] = q[3];
        q = quarter_round(x[10], x[14], x[2], x[6]);
        y[10] = q[0]; y[14] = q[1]; y[2] = q[2];  y[6] = q[3];
        q = quarter_round(x[15], x[3], x[7], x[11]);
        y[15] = q[0]; y[3] = q[1];  y[7] = q[2];  y[11] = q[3];
        return y;
    endfunction

    function automatic matrix_t row_round(matrix_t x);
        matrix_t y;
        quad_t q;
        y = x;
        q = quarter_round(x[0], x[1], x[2], x[3]);
        y[0] = q[0];  y[1] = q[1];  y[2] = q[2];  y[3] = q[3];
        q = quarter_round(x[5], x[6], x[7], x[4]);
        y[5] = q[0];  y[6] = q[1];  y[7] = q[2];  y[4] = q[3];
        q = quarter_round(x[10], x[11], x[8], x[9]);
        y[10] = q[0]; y[11] = q[1]; y[8] = q[2];  y[9] = q[3];
        q = quarter_round(x[15], x[12], x[13], x[14]);
        y[15] = q[0]; y[12] = q[1]; y[13] = q[2]; y[14] = q[3];
        return y;
    endfunction

    function automatic matrix_t build_matrix(logic [63:0] k0, logic [63:0] k1,
                                             logic [63:0] k2, logic [63:0] k3,
                                             logic [63:0] nonce, logic [63:0] ctr);
        matrix_t m;
        m[0]  = SIGMA0;
        m[1]  = k0[31:0];
        m[2]  = k0[63:32];
        m[3]  = k1[31:0];
        m[4]  = k1[63:32];
        m[5]  = SIGMA1;
        m[6]  = nonce[31:0];
        m[7]  = nonce[63:32];
        m[8]  = ctr[31:0];
        m[9]  = ctr[63:32];
        m[10] = SIGMA2;
        m[11] = k2[31:0];
        m[12] = k2[63:32];
        m[13] = k3[31:0];
        m[14] = k3[63:32];
        m[15] = SIGMA3;
        return m;
    endfunction

endpackage

### rtl/core/salsa_ctrl.sv
// Salsa20 controller: sequences input transfer, block generation and output.
// Depends on salsa_pkg.
module salsa_ctrl
    import salsa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [ROUNDS_W-1:0] cnt_reg, cnt_next;
    logic [ROUNDS_W-1:0] cnt_inc;

    assign in_ready = (state_reg == ST_IDLE);
    assign cnt_inc  = cnt_reg + 5'd1;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    if (status.block_needed) begin
                        cmd.load = 1'b1;
                        cnt_next = '0;
                        if (status.half_rounds == '0) begin
                            state_next = ST_FINAL;
                        end else begin
                            state_next = ST_ROUND;
                        end
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                cmd.row   = cnt_reg[0];
                cnt_next  = cnt_inc;
                if (cnt_inc == status.half_rounds) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/core/salsa_datapath.sv
// Salsa20 datapath: config registers, working/keystream matrix, block counter,
// word position and output register. Depends on salsa_pkg.
module salsa_datapath
    import salsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [63:0]          cfg_wdata,
    input  logic [DATA_W-1:0]    in_data,
    input  logic [COUNT_W-1:0]   in_count,
    input  logic                 in_first,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [DATA_W-1:0]    out_data,
    output logic [COUNT_W-1:0]   out_count,
    input  dp_cmd_t              cmd,
    output dp_status_t           status
);

    logic [63:0]         key0_reg, key1_reg, key2_reg, key3_reg, nonce_reg;
    logic [31:0]         init_ctr_reg;
    logic [ROUNDS_W-1:0] rounds_reg;

    logic [63:0]         counter_reg, counter_next;
    logic [2:0]          pos_reg, pos_next;
    matrix_t             x_reg, x_next;
    logic [DATA_W-1:0]   data_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic [COUNT_W-1:0]  out_count_reg;

    logic [63:0]         ctr_eff;
    matrix_t             m_load, m_ff;
    logic [DATA_W-1:0]   ks;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            nonce_reg    <= '0;
            init_ctr_reg <= '0;
            rounds_reg   <= ROUNDS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_KEY0:     key0_reg     <= cfg_wdata;
                REG_KEY1:     key1_reg     <= cfg_wdata;
                REG_KEY2:     key2_reg     <= cfg_wdata;
                REG_KEY3:     key3_reg     <= cfg_wdata;
                REG_NONCE:    nonce_reg    <= cfg_wdata;
                REG_INIT_CTR: init_ctr_reg <= cfg_wdata[31:0];
                REG_ROUNDS:   rounds_reg   <= cfg_wdata[ROUNDS_W-1:0];
                default: ;
            endcase
        end
    end

    assign ctr_eff = in_first ? {32'd0, init_ctr_reg} : counter_reg;
    assign m_load  = build_matrix(key0_reg, key1_reg, key2_reg, key3_reg, nonce_reg, ctr_eff);
    assign m_ff    = build_matrix(key0_reg, key1_reg, key2_reg, key3_reg, nonce_reg,
                                  counter_reg);

    always_comb begin
        x_next = x_reg;
        if (cmd.load) begin
            x_next = m_load;
        end else if (cmd.round) begin
            x_next = cmd.row ? row_round(x_reg) : column_round(x_reg);
        end else if (cmd.finish) begin
            for (int i = 0; i < 16; i++) begin
                x_next[i] = x_reg[i] + m_ff[i];
            end
        end
    end

    always_comb begin
        counter_next = counter_reg;
        pos_next     = pos_reg;
        if (cmd.accept && in_first) begin
            counter_next = {32'd0, init_ctr_reg};
            pos_next     = '0;
        end
        if (cmd.finish) begin
            counter_next = counter_reg + 64'd1;
        end
        if (cmd.emit) begin
            pos_next = pos_reg + 3'd1;
        end
    end

    assign ks = {x_reg[{pos_reg, 1'b1}], x_reg[{pos_reg, 1'b0}]};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            out_data_next[8*i +: 8] = (count_reg > 4'(i)) ?
                                      (data_reg[8*i +: 8] ^ ks[8*i +: 8]) : 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg   <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            counter_reg <= counter_next;
            pos_reg     <= pos_next;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        if (cmd.accept) begin
            data_reg  <= in_data;
            count_reg <= in_count;
        end
        if (cmd.emit) begin
            out_data_reg  <= out_data_next;
            out_count_reg <= count_reg;
        end
    end

    assign status.block_needed = in_first || (pos_reg == 3'd0);
    assign status.half_rounds  = {rounds_reg[ROUNDS_W-1:1], 1'b0};
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_count = out_count_reg;

endmodule

### rtl/core/salsa20_stream_cipher_top.sv
// Salsa20 stream cipher top level (256-bit key): stream ports and config port.
// Depends on salsa_pkg, salsa_ctrl and salsa_datapath.
//
// Usage:
//   Write key, nonce, initial counter and round count through cfg_we/cfg_addr/
//   cfg_wdata while the block is idle. Send 8-byte words on the s_ channel;
//   each transfer yields one m_ transfer holding data XOR keystream, with
//   bytes at or above the byte count forced to zero and the count echoed.
//   A set first-word flag reloads the block counter and restarts the keystream.
//   A word inside a block goes from its input transfer through the EMIT state
//   into the output register. A word that starts a block first runs the round
//   unit, one half round per cycle, for 2*floor(rounds/2) half rounds, then the feed-forward add.
//   Only one word is in flight: a new word is taken once the previous one has
//   moved into the output register; each keystream block serves eight words.
//   Reset (aresetn, synchronous, active low) clears config to defaults
//   (rounds = 20), counter, word position and the output valid flag.
//   When m_tready is low the result holds in the output register; a new word
//   is still taken and processed, and waits for the register to drain.
module salsa20_stream_cipher_top
    import salsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [63:0]          cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [63:0] in_data, [67:64] byte_count, rest zero
    input  logic                 s_tuser,   // [0] first_word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata    // [63:0] out_data, [67:64] valid_bytes, rest zero
);

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [DATA_W-1:0]  out_data;
    logic [COUNT_W-1:0] out_count;

    salsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    salsa_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata[DATA_W-1:0]),
        .in_count  (s_tdata[DATA_W +: COUNT_W]),
        .in_first  (s_tuser),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_count (out_count),
        .cmd       (cmd),
        .status    (status)
    );

    assign m_tdata = {{(TDATA_W - DATA_W - COUNT_W){1'b0}}, out_count, out_data};

endmodule
